>>> rtl/core/aes_pkg.sv
// package with cipher tables, codes and round helper functions
package aes_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_0_7 = 3'd1;
	localparam logic [2:0] REG_KEY_8_15 = 3'd2;
	localparam logic [2:0] REG_KEY_16_23 = 3'd3;
	localparam logic [2:0] REG_KEY_24_31 = 3'd4;

	// key size codes
	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;

	// item mode codes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam int MAX_ROUNDS = 14;
	localparam int SCHED_WORDS = 4 * (MAX_ROUNDS + 1);
	localparam int WIN_WORDS = 8;

	typedef logic [127:0] state_t;
	typedef logic [31:0] word_t;

	// forward substitution table, entry 0 in the top byte
	localparam logic [2047:0] SBOX_BITS = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	// inverse substitution table
	localparam logic [2047:0] INV_SBOX_BITS = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX_BITS[{~b, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] b);
		return INV_SBOX_BITS[{~b, 3'b111} -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// rounds for a key size; the unused code runs as 256 bits
	function automatic logic [3:0] num_rounds(input logic [1:0] ks);
		logic [3:0] nr;
		case (ks)
			KS_128: nr = 4'd10;
			KS_192: nr = 4'd12;
			default: nr = 4'd14;
		endcase
		return nr;
	endfunction

	function automatic word_t sub_word(input word_t w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic state_t sub_bytes(input state_t s);
		state_t t;
		for (int i = 0; i < 16; i++) begin
			t[127 - 8 * i -: 8] = sbox(s[127 - 8 * i -: 8]);
		end
		return t;
	endfunction

	function automatic state_t inv_sub_bytes(input state_t s);
		state_t t;
		for (int i = 0; i < 16; i++) begin
			t[127 - 8 * i -: 8] = inv_sbox(s[127 - 8 * i -: 8]);
		end
		return t;
	endfunction

	// row r of column c takes the byte of column c + r
	function automatic state_t shift_rows(input state_t s);
		state_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8];
			end
		end
		return t;
	endfunction

	function automatic state_t inv_shift_rows(input state_t s);
		state_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = s[127 - 8 * (r + 4 * c) -: 8];
			end
		end
		return t;
	endfunction

	function automatic word_t mix_word(input word_t w);
		logic [7:0] a [4];
		word_t t;
		for (int r = 0; r < 4; r++) begin
			a[r] = w[31 - 8 * r -: 8];
		end
		for (int r = 0; r < 4; r++) begin
			t[31 - 8 * r -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
				^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
		end
		return t;
	endfunction

	function automatic word_t inv_mix_word(input word_t w);
		logic [7:0] a [4];
		logic [7:0] m2 [4];
		logic [7:0] m4 [4];
		logic [7:0] m8 [4];
		word_t t;
		for (int r = 0; r < 4; r++) begin
			a[r] = w[31 - 8 * r -: 8];
			m2[r] = xtime(a[r]);
			m4[r] = xtime(m2[r]);
			m8[r] = xtime(m4[r]);
		end
		// coefficients 0e, 0b, 0d, 09
		for (int r = 0; r < 4; r++) begin
			t[31 - 8 * r -: 8] = (m8[r] ^ m4[r] ^ m2[r])
				^ (m8[(r + 1) % 4] ^ m2[(r + 1) % 4] ^ a[(r + 1) % 4])
				^ (m8[(r + 2) % 4] ^ m4[(r + 2) % 4] ^ a[(r + 2) % 4])
				^ (m8[(r + 3) % 4] ^ a[(r + 3) % 4]);
		end
		return t;
	endfunction

	function automatic state_t mix_columns(input state_t s);
		state_t t;
		for (int c = 0; c < 4; c++) begin
			t[127 - 32 * c -: 32] = mix_word(s[127 - 32 * c -: 32]);
		end
		return t;
	endfunction

	function automatic state_t inv_mix_columns(input state_t s);
		state_t t;
		for (int c = 0; c < 4; c++) begin
			t[127 - 32 * c -: 32] = inv_mix_word(s[127 - 32 * c -: 32]);
		end
		return t;
	endfunction

endpackage

>>> rtl/core/aes_block_cipher_core.sv
// aes encrypt/decrypt core with one unrolled round per pipeline stage
//
// Usage:
// - key registers are written through wr_en / wr_index / wr_data while the
//   core is idle; index 0 is the key size, 1 to 4 the key bytes 0..31
// - after reset and after every register write the round key schedule is
//   expanded one word a cycle (44, 52 or 60 words for 128, 192 or 256 bit
//   keys); busy stays high meanwhile and no block is taken
// - a block transfer happens at a clock edge with start high and busy low;
//   mode selects encrypt or decrypt, block_high / block_low carry the data
// - one block can enter every cycle while busy is low; each block passes the
//   initial key add and fourteen round stages, each a register, before the
//   cycle in which done is high with the result
// - shorter keys pass the stages past their last round unchanged, so the
//   latency is the same for every key size
// - done is high for exactly one cycle per block and the result must be
//   taken then; the receiver cannot hold results off
// - reset clears the key registers to zero and starts the expansion
module aes_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data
);

	localparam int NS = aes_pkg::MAX_ROUNDS;

	// configuration registers
	logic [1:0]  key_size_q;
	logic [63:0] key_q [4];

	// key expansion state
	logic                busy_q;
	logic [5:0]          ks_idx_q;
	logic [2:0]          ks_k_q;
	logic [7:0]          ks_rcon_q;
	aes_pkg::word_t      win_q [aes_pkg::WIN_WORDS];
	aes_pkg::word_t      sched_q [aes_pkg::SCHED_WORDS];

	logic [3:0]          nr;
	logic [3:0]          nk;
	logic [2:0]          nk_last;
	aes_pkg::word_t      ks_prev;
	aes_pkg::word_t      ks_back;
	aes_pkg::word_t      ks_word;
	logic [63:0]         ks_reg;
	logic                ks_fill;

	// pipeline
	aes_pkg::state_t     state_s [NS + 1];
	logic                mode_s [NS + 1];
	logic                vld_s [NS + 1];
	aes_pkg::state_t     rk_all [NS + 1];
	aes_pkg::state_t     init_key;
	logic                accept;

	assign nr = aes_pkg::num_rounds(key_size_q);
	assign nk = nr - 4'd6;
	assign nk_last = 3'(nk - 4'd1);
	assign accept = start && !busy_q;
	assign busy = busy_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= aes_pkg::KS_128;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				aes_pkg::REG_KEY_SIZE: key_size_q <= wr_data[1:0];
				aes_pkg::REG_KEY_0_7: key_q[0] <= wr_data;
				aes_pkg::REG_KEY_8_15: key_q[1] <= wr_data;
				aes_pkg::REG_KEY_16_23: key_q[2] <= wr_data;
				aes_pkg::REG_KEY_24_31: key_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// next schedule word: key register words first, then from the sliding window of recent words
	always_comb begin
		ks_prev = win_q[0];
		case (key_size_q)
			aes_pkg::KS_128: ks_back = win_q[3];
			aes_pkg::KS_192: ks_back = win_q[5];
			default: ks_back = win_q[7];
		endcase
		ks_reg = key_q[ks_idx_q[2:1]];
		ks_fill = ({2'b00, ks_idx_q} < {4'd0, nk});
		if (ks_fill) begin
			ks_word = ks_idx_q[0] ? ks_reg[31:0] : ks_reg[63:32];
		end else if (ks_k_q == 3'd0) begin
			ks_word = ks_back ^ aes_pkg::sub_word({ks_prev[23:0], ks_prev[31:24]})
				^ {ks_rcon_q, 24'h000000};
		end else if (nk == 4'd8 && ks_k_q == 3'd4) begin
			ks_word = ks_back ^ aes_pkg::sub_word(ks_prev);
		end else begin
			ks_word = ks_back ^ ks_prev;
		end
	end

	// key expansion sequencer, restarted by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			ks_idx_q <= '0;
			ks_k_q <= '0;
			ks_rcon_q <= 8'h01;
		end else if (wr_en) begin
			busy_q <= 1'b1;
			ks_idx_q <= '0;
			ks_k_q <= '0;
			ks_rcon_q <= 8'h01;
		end else if (busy_q) begin
			ks_idx_q <= ks_idx_q + 6'd1;
			ks_k_q <= (ks_k_q == nk_last) ? 3'd0 : ks_k_q + 3'd1;
			if (!ks_fill && ks_k_q == 3'd0) begin
				ks_rcon_q <= aes_pkg::xtime(ks_rcon_q);
			end
			if (ks_idx_q == {nr, 2'b11}) begin
				busy_q <= 1'b0;
			end
		end
	end

	// schedule storage and window
	always_ff @(posedge clk) begin
		if (busy_q && !wr_en) begin
			sched_q[ks_idx_q] <= ks_word;
			win_q[0] <= ks_word;
			for (int i = 1; i < aes_pkg::WIN_WORDS; i++) begin
				win_q[i] <= win_q[i - 1];
			end
		end
	end

	// round keys as 128-bit groups
	always_comb begin
		for (int x = 0; x <= NS; x++) begin
			rk_all[x] = {sched_q[4 * x], sched_q[4 * x + 1], sched_q[4 * x + 2],
				sched_q[4 * x + 3]};
		end
	end

	// initial key add: key 0 for encrypt, last key for decrypt
	always_comb begin
		if (mode == aes_pkg::MODE_DEC) begin
			case (key_size_q)
				aes_pkg::KS_128: init_key = rk_all[10];
				aes_pkg::KS_192: init_key = rk_all[12];
				default: init_key = rk_all[14];
			endcase
		end else begin
			init_key = rk_all[0];
		end
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			state_s[0] <= {block_high, block_low} ^ init_key;
			mode_s[0] <= mode;
		end
	end

	// round stages
	for (genvar j = 1; j <= NS; j++) begin : g_round
		localparam int D10 = (j <= 10) ? 10 - j : 0;
		localparam int D12 = (j <= 12) ? 12 - j : 0;
		localparam int D14 = (j <= 14) ? 14 - j : 0;

		aes_pkg::state_t rk;
		aes_pkg::state_t nxt;
		aes_pkg::state_t fwd;
		aes_pkg::state_t inv;

		// key for this stage: round j forward, round nr - j inverse
		always_comb begin
			if (mode_s[j - 1] == aes_pkg::MODE_DEC) begin
				case (key_size_q)
					aes_pkg::KS_128: rk = rk_all[D10];
					aes_pkg::KS_192: rk = rk_all[D12];
					default: rk = rk_all[D14];
				endcase
			end else begin
				rk = rk_all[j];
			end
		end

		// full round, last round without column mix, or pass-through
		always_comb begin
			fwd = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_s[j - 1]));
			inv = aes_pkg::inv_sub_bytes(aes_pkg::inv_shift_rows(state_s[j - 1])) ^ rk;
			if (4'(j) > nr) begin
				nxt = state_s[j - 1];
			end else if (mode_s[j - 1] == aes_pkg::MODE_DEC) begin
				nxt = (4'(j) == nr) ? inv : aes_pkg::inv_mix_columns(inv);
			end else begin
				nxt = ((4'(j) == nr) ? fwd : aes_pkg::mix_columns(fwd)) ^ rk;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[j - 1]) begin
				state_s[j] <= nxt;
				mode_s[j] <= mode_s[j - 1];
			end
		end
	end

	assign done = vld_s[NS];
	assign result_high = state_s[NS][127:64];
	assign result_low = state_s[NS][63:0];

`ifndef SYNTHESIS
	// every result comes from a block taken a fixed latency earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, NS + 1))
		else $error("result without a matching block transfer");

	// a register write always reruns the key expansion
	a_write_expands: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> busy)
		else $error("key expansion not restarted by register write");

	// expansion ends only after the last schedule word
	a_expand_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(ks_idx_q) == {nr, 2'b11})
		else $error("key expansion ended early");
`endif

endmodule
